// ===== design/frot_pkg.sv =====
// Shared types, widths and helpers for the RGB565 frame rotator.
// No dependencies; the interfaces, the rotator and the checker import this package.
`default_nettype none

package frot_pkg;

	// Field and register widths
	localparam int PIX_W      = 16;
	localparam int DIM_W      = 11;
	localparam int MAX_DIM    = 1024;
	localparam int CNT_W      = $clog2(MAX_DIM);
	localparam int DADDR_W    = 20;
	localparam int PTR_W      = 20;
	localparam int PROD_W     = 2 * DIM_W;
	localparam int ROT_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DIM_W;

	// Register reset values
	localparam logic [ROT_W-1:0] ROT_RESET        = ROT_W'(1);
	localparam logic [DIM_W-1:0] SRC_WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] SRC_HEIGHT_RESET = DIM_W'(480);
	localparam logic [DIM_W-1:0] SRC_PITCH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] DST_PITCH_RESET  = DIM_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROTATION   = 3'd0,
		CFG_SRC_WIDTH  = 3'd1,
		CFG_SRC_HEIGHT = 3'd2,
		CFG_SRC_PITCH  = 3'd3,
		CFG_DST_PITCH  = 3'd4
	} cfg_reg_t;

	typedef enum logic [ROT_W-1:0] {
		ROT_NONE = 2'd0,
		ROT_90   = 2'd1,
		ROT_270  = 2'd2
	} rot_t;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_EMIT = 1'b1
	} mode_t;

	// Zero acts as one, anything past the largest frame side acts as that side
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/frot_if.sv =====
// Valid/ready channel interfaces for the frame rotator input and result items.
// Depends on frot_pkg for field widths.
`default_nettype none

interface frot_in_if import frot_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output mode, output pixel_in, input ready);
	modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface frot_out_if import frot_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DADDR_W-1:0] dst_address;
	logic [PIX_W-1:0]   pixel_out;
	logic               frame_last;

	modport source (output valid, output dst_address, output pixel_out, output frame_last,
		input ready);
	modport sink   (input valid, input dst_address, input pixel_out, input frame_last,
		output ready);
endinterface

`default_nettype wire

// ===== design/frot_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module frot_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/rgb565_frame_rotator.sv =====
// RGB565 frame rotator: loads a source frame into a frame store, then emits it
// rotated by 0, 90 or 270 degrees in destination raster order.
// An emit item passes the stage 1 register, then the row products, then the
// registered store read before its result is valid.
// Throughput: one item per cycle while results are taken; a stalled result holds the input.
// Reset clears registers to defaults, counters and load pointer; store is not cleared.
`default_nettype none

module rgb565_frame_rotator import frot_pkg::*; #(
	parameter int FRAME_PIXELS = 524288
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	frot_in_if.sink               item_in,
	frot_out_if.source            item_out
);

	localparam int AW = $clog2(FRAME_PIXELS);
	localparam logic [PROD_W-1:0] FRAME_LIMIT = PROD_W'(FRAME_PIXELS);

	// Configuration registers
	logic [ROT_W-1:0] rotation_q;
	logic [DIM_W-1:0] src_width_q, src_height_q, src_pitch_q, dst_pitch_q;

	// Frame state
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] col_q, row_q;

	// Pipeline
	logic             emit_s1, wr_s1;
	logic [CNT_W-1:0] x_s1, y_s1, sx_s1, sy_s1;
	logic             last_s1;
	logic [AW-1:0]    waddr_s1;
	logic [PIX_W-1:0] wdata_s1;

	logic              emit_s2, wr_s2;
	logic [PROD_W-1:0] psrc_s2, pdst_s2;
	logic [CNT_W-1:0]  x_s2, sx_s2;
	logic              last_s2;
	logic [AW-1:0]     waddr_s2;
	logic [PIX_W-1:0]  wdata_s2;

	logic               valid_s3;
	logic [DADDR_W-1:0] daddr_s3;
	logic               last_s3;
	logic               inrange_s3;

	// Combinational
	logic              adv, acc, is_emit;
	logic [DIM_W-1:0]  sw, sh, dw, dh, row_t, x_p1, y_p1;
	rot_t              rot_eff;
	logic              col_wrap, last, load_ok;
	logic [CNT_W-1:0]  x, y, sx, sy, col_nx, row_nx;
	logic [PROD_W-1:0] limit, saddr, daddr;
	logic              in_range;
	logic [PIX_W-1:0]  rdata;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q   <= ROT_RESET;
			src_width_q  <= SRC_WIDTH_RESET;
			src_height_q <= SRC_HEIGHT_RESET;
			src_pitch_q  <= SRC_PITCH_RESET;
			dst_pitch_q  <= DST_PITCH_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ROTATION:   rotation_q   <= cfg_wdata[ROT_W-1:0];
				CFG_SRC_WIDTH:  src_width_q  <= cfg_wdata;
				CFG_SRC_HEIGHT: src_height_q <= cfg_wdata;
				CFG_SRC_PITCH:  src_pitch_q  <= cfg_wdata;
				CFG_DST_PITCH:  dst_pitch_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Global advance: everything moves unless a result is stalled at the output
	assign adv           = !valid_s3 || item_out.ready;
	assign item_in.ready = adv;
	assign acc           = item_in.valid && adv;
	assign is_emit       = item_in.mode == MODE_EMIT;

	// Destination position, source position and counter step
	always_comb begin
		sw = clamp_dim(src_width_q);
		sh = clamp_dim(src_height_q);
		case (rotation_q)
			ROT_90:  rot_eff = ROT_90;
			ROT_270: rot_eff = ROT_270;
			default: rot_eff = ROT_NONE;
		endcase
		dw = (rot_eff == ROT_NONE) ? sw : sh;
		dh = (rot_eff == ROT_NONE) ? sh : sw;

		// stale counters after a register change wrap onto the frame
		col_wrap = DIM_W'(col_q) >= dw;
		row_t    = col_wrap ? DIM_W'(row_q) + DIM_W'(1) : DIM_W'(row_q);
		x        = col_wrap ? '0 : col_q;
		y        = (row_t >= dh) ? '0 : row_t[CNT_W-1:0];
		x_p1     = DIM_W'(x) + DIM_W'(1);
		y_p1     = DIM_W'(y) + DIM_W'(1);
		last     = (x_p1 >= dw) && (y_p1 >= dh);

		case (rot_eff)
			ROT_90: begin
				sx = y;
				sy = CNT_W'(sh - DIM_W'(1) - DIM_W'(x));
			end
			ROT_270: begin
				sx = CNT_W'(sw - DIM_W'(1) - DIM_W'(y));
				sy = x;
			end
			default: begin
				sx = x;
				sy = y;
			end
		endcase

		if (x_p1 >= dw) begin
			col_nx = '0;
			row_nx = y_p1[CNT_W-1:0];
		end else begin
			col_nx = x_p1[CNT_W-1:0];
			row_nx = y;
		end

		limit   = PROD_W'(src_pitch_q) * PROD_W'(sh);
		load_ok = (PROD_W'(ptr_q) < limit) && (PROD_W'(ptr_q) < FRAME_LIMIT);
	end

	// Load pointer and output counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (is_emit) begin
				if (last) begin
					col_q <= '0;
					row_q <= '0;
					ptr_q <= '0;
				end else begin
					col_q <= col_nx;
					row_q <= row_nx;
				end
			end else if (load_ok) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			wr_s1   <= 1'b0;
		end else if (adv) begin
			emit_s1 <= acc && is_emit;
			wr_s1   <= acc && !is_emit && load_ok;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1     <= x;
			y_s1     <= y;
			sx_s1    <= sx;
			sy_s1    <= sy;
			last_s1  <= last;
			waddr_s1 <= ptr_q[AW-1:0];
			wdata_s1 <= item_in.pixel_in;
		end
	end

	// Stage 2: source and destination row products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			wr_s2   <= 1'b0;
		end else if (adv) begin
			emit_s2 <= emit_s1;
			wr_s2   <= wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			psrc_s2  <= PROD_W'(sy_s1) * PROD_W'(src_pitch_q);
			pdst_s2  <= PROD_W'(y_s1) * PROD_W'(dst_pitch_q);
			x_s2     <= x_s1;
			sx_s2    <= sx_s1;
			last_s2  <= last_s1;
			waddr_s2 <= waddr_s1;
			wdata_s2 <= wdata_s1;
		end
	end

	// Addresses; the store is written and read in the same stage to keep item order
	assign saddr    = psrc_s2 + PROD_W'(sx_s2);
	assign daddr    = pdst_s2 + PROD_W'(x_s2);
	assign in_range = saddr < FRAME_LIMIT;

	frot_ram #(
		.WIDTH (PIX_W),
		.DEPTH (FRAME_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (adv && wr_s2),
		.waddr (waddr_s2),
		.wdata (wdata_s2),
		.re    (adv && emit_s2),
		.raddr (saddr[AW-1:0]),
		.rdata (rdata)
	);

	// Stage 3: result register, pixel from the store read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv)
			valid_s3 <= emit_s2;
	end

	always_ff @(posedge clk) begin
		if (adv && emit_s2) begin
			daddr_s3   <= daddr[DADDR_W-1:0];
			last_s3    <= last_s2;
			inrange_s3 <= in_range;
		end
	end

	assign item_out.valid       = valid_s3;
	assign item_out.dst_address = daddr_s3;
	assign item_out.pixel_out   = inrange_s3 ? rdata : '0;
	assign item_out.frame_last  = last_s3;

endmodule

`default_nettype wire

// ===== design/frot_checker.sv =====
// Port-level checks for the frame rotator, bound to the top level.
// Depends on frot_pkg and the channel interfaces of rgb565_frame_rotator.
`default_nettype none

module frot_checker import frot_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [DADDR_W-1:0] out_dst_address,
	input wire logic [PIX_W-1:0]   out_pixel,
	input wire logic               out_frame_last
);

	logic last_seen_q;

	// Remember whether the last item taken closed a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_seen_q <= 1'b0;
		else if (out_valid && out_ready)
			last_seen_q <= out_frame_last;
	end

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_dst_address)
			&& $stable(out_pixel) && $stable(out_frame_last))
		else $error("stalled result changed");

	// Nothing is taken while a result is stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken during output stall");

	// With the output empty the block always takes an item
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("not ready with empty output");

	// The first pixel after a frame end sits at destination address zero
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_seen_q |-> out_dst_address == '0)
		else $error("new frame does not start at address zero");

endmodule

bind rgb565_frame_rotator frot_checker u_frot_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (item_in.ready),
	.out_valid       (item_out.valid),
	.out_ready       (item_out.ready),
	.out_dst_address (item_out.dst_address),
	.out_pixel       (item_out.pixel_out),
	.out_frame_last  (item_out.frame_last)
);

`default_nettype wire
